// ===== design/vmx_pkg.sv =====
package vmx_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_W     = $clog2(WORD_BITS);

    localparam logic [3:0] FLG_NONE    = 4'b0000;
    localparam logic [3:0] FLG_ZERO    = 4'b0001;
    localparam logic [3:0] FLG_EQUAL   = 4'b0010;
    localparam logic [3:0] FLG_GREATER = 4'b0100;
    localparam logic [3:0] FLG_LESS    = 4'b1000;

    typedef enum logic [4:0] {
        OP_NOP   = 5'd0,
        OP_HALT  = 5'd1,
        OP_INT   = 5'd2,
        OP_MOV   = 5'd3,
        OP_JMP   = 5'd4,
        OP_INC   = 5'd5,
        OP_DEC   = 5'd6,
        OP_ADD   = 5'd7,
        OP_SUB   = 5'd8,
        OP_MUL   = 5'd9,
        OP_DIV   = 5'd10,
        OP_SHOW  = 5'd11,
        OP_CMP   = 5'd12,
        OP_SCMP  = 5'd13,
        OP_TEST  = 5'd14,
        OP_STEST = 5'd15,
        OP_JZ    = 5'd16,
        OP_JNZ   = 5'd17,
        OP_JEQ   = 5'd18,
        OP_JNEQ  = 5'd19,
        OP_JGT   = 5'd20,
        OP_JNGT  = 5'd21,
        OP_JLT   = 5'd22,
        OP_JNLT  = 5'd23,
        OP_AND   = 5'd24,
        OP_OR    = 5'd25,
        OP_XOR   = 5'd26,
        OP_NOT   = 5'd27
    } t_op;

    typedef struct packed {
        logic load;
        logic finish;
        logic div_start;
        logic div_step;
    } t_dp_cmd;

    typedef struct packed {
        logic div_go;
        logic div_last;
    } t_dp_status;

endpackage

// ===== design/vmx_ctrl.sv =====
module vmx_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_stall,
    input  vmx_pkg::t_dp_status i_status,
    output vmx_pkg::t_dp_cmd    o_cmd,
    output logic                o_in_stall,
    output logic                o_out_valid
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_DFIN,
        ST_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = i_status.div_go ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = ST_DFIN;
                end
            end
            ST_DFIN: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.load      = (r_state == ST_IDLE) && i_valid;
    assign o_cmd.finish    = ((r_state == ST_EXEC) && !i_status.div_go) || (r_state == ST_DFIN);
    assign o_cmd.div_start = (r_state == ST_EXEC) && i_status.div_go;
    assign o_cmd.div_step  = (r_state == ST_DIV);
    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = (r_state == ST_OUT);

endmodule

// ===== design/vmx_dp.sv =====
module vmx_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vmx_pkg::t_dp_cmd                    i_cmd,
    input  logic [4:0]                          i_command,
    input  logic [vmx_pkg::WORD_BITS-1:0]       i_value_a,
    input  logic [vmx_pkg::WORD_BITS-1:0]       i_value_b,
    output vmx_pkg::t_dp_status                 o_status,
    output logic                                o_write_dest,
    output logic [vmx_pkg::WORD_BITS-1:0]       o_result_value,
    output logic                                o_write_remainder,
    output logic [vmx_pkg::WORD_BITS-1:0]       o_remainder_value,
    output logic                                o_jump_taken,
    output logic [vmx_pkg::WORD_BITS-1:0]       o_jump_target,
    output logic                                o_divide_error,
    output logic [3:0]                          o_flags_now
);

    localparam int W = vmx_pkg::WORD_BITS;

    vmx_pkg::t_op                r_cmd;
    logic [W-1:0]                r_a;
    logic [W-1:0]                r_b;
    logic [3:0]                  r_flags;
    logic [W-1:0]                r_quot;
    logic [W-1:0]                r_rem;
    logic [vmx_pkg::CNT_W-1:0]   r_cnt;

    logic                        r_wd;
    logic [W-1:0]                r_res;
    logic                        r_wr;
    logic [W-1:0]                r_remv;
    logic                        r_jt;
    logic [W-1:0]                r_tgt;
    logic                        r_derr;

    logic                        n_wd;
    logic [W-1:0]                n_res;
    logic                        n_wr;
    logic [W-1:0]                n_remv;
    logic                        n_jt;
    logic [W-1:0]                n_tgt;
    logic                        n_derr;
    logic [3:0]                  n_flags;

    logic [W-1:0]                w_prod;
    logic [W:0]                  w_shift;
    logic [W:0]                  w_diff;
    logic                        w_qbit;
    logic                        w_is_jump;
    logic                        w_cond;

    assign w_prod  = r_a * r_b;
    assign w_shift = {r_rem, r_quot[W-1]};
    assign w_diff  = w_shift - {1'b0, r_b};
    assign w_qbit  = !w_diff[W];

    assign o_status.div_go   = (r_cmd == vmx_pkg::OP_DIV) && (r_b != '0);
    assign o_status.div_last = (r_cnt == vmx_pkg::CNT_W'(W - 1));

    always_comb begin
        n_wd      = 1'b0;
        n_res     = '0;
        n_wr      = 1'b0;
        n_remv    = '0;
        n_derr    = 1'b0;
        n_flags   = r_flags;
        w_is_jump = 1'b0;
        w_cond    = 1'b0;
        unique case (r_cmd)
            vmx_pkg::OP_MOV: begin n_wd = 1'b1; n_res = r_b; end
            vmx_pkg::OP_JMP: begin w_is_jump = 1'b1; w_cond = 1'b1; end
            vmx_pkg::OP_INC: begin n_wd = 1'b1; n_res = r_a + W'(1); end
            vmx_pkg::OP_DEC: begin n_wd = 1'b1; n_res = r_a - W'(1); end
            vmx_pkg::OP_ADD: begin n_wd = 1'b1; n_res = r_a + r_b; end
            vmx_pkg::OP_SUB: begin n_wd = 1'b1; n_res = r_a - r_b; end
            vmx_pkg::OP_MUL: begin n_wd = 1'b1; n_res = w_prod; end
            vmx_pkg::OP_DIV: begin
                if (r_b == '0) begin
                    n_derr = 1'b1;
                end else begin
                    n_wd   = 1'b1;
                    n_res  = r_quot;
                    n_wr   = 1'b1;
                    n_remv = r_rem;
                end
            end
            vmx_pkg::OP_CMP: begin
                if (r_a == r_b) begin
                    n_flags = vmx_pkg::FLG_EQUAL;
                end else if (r_a > r_b) begin
                    n_flags = vmx_pkg::FLG_GREATER;
                end else begin
                    n_flags = vmx_pkg::FLG_LESS;
                end
            end
            vmx_pkg::OP_SCMP: begin
                if (r_a == r_b) begin
                    n_flags = vmx_pkg::FLG_EQUAL;
                end else if ($signed(r_a) > $signed(r_b)) begin
                    n_flags = vmx_pkg::FLG_GREATER;
                end else begin
                    n_flags = vmx_pkg::FLG_LESS;
                end
            end
            vmx_pkg::OP_TEST: begin
                n_flags = (r_a == '0) ? vmx_pkg::FLG_ZERO : vmx_pkg::FLG_GREATER;
            end
            vmx_pkg::OP_STEST: begin
                if (r_a == '0) begin
                    n_flags = vmx_pkg::FLG_ZERO;
                end else if (r_a[W-1]) begin
                    n_flags = vmx_pkg::FLG_LESS;
                end else begin
                    n_flags = vmx_pkg::FLG_GREATER;
                end
            end
            vmx_pkg::OP_JZ:   begin w_is_jump = 1'b1; w_cond = r_flags[0]; end
            vmx_pkg::OP_JNZ:  begin w_is_jump = 1'b1; w_cond = !r_flags[0]; end
            vmx_pkg::OP_JEQ:  begin w_is_jump = 1'b1; w_cond = r_flags[1]; end
            vmx_pkg::OP_JNEQ: begin w_is_jump = 1'b1; w_cond = !r_flags[1]; end
            vmx_pkg::OP_JGT:  begin w_is_jump = 1'b1; w_cond = r_flags[2]; end
            vmx_pkg::OP_JNGT: begin w_is_jump = 1'b1; w_cond = !r_flags[2]; end
            vmx_pkg::OP_JLT:  begin w_is_jump = 1'b1; w_cond = r_flags[3]; end
            vmx_pkg::OP_JNLT: begin w_is_jump = 1'b1; w_cond = !r_flags[3]; end
            vmx_pkg::OP_AND:  begin n_wd = 1'b1; n_res = r_a & r_b; end
            vmx_pkg::OP_OR:   begin n_wd = 1'b1; n_res = r_a | r_b; end
            vmx_pkg::OP_XOR:  begin n_wd = 1'b1; n_res = r_a ^ r_b; end
            vmx_pkg::OP_NOT:  begin n_wd = 1'b1; n_res = ~r_a; end
            default: begin
            end
        endcase
        n_jt  = w_is_jump && w_cond;
        n_tgt = w_is_jump ? r_a : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= vmx_pkg::FLG_NONE;
        end else if (i_cmd.finish) begin
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= vmx_pkg::t_op'(i_command);
            r_a   <= i_value_a;
            r_b   <= i_value_b;
        end
        if (i_cmd.div_start) begin
            r_quot <= r_a;
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.div_step) begin
            r_quot <= {r_quot[W-2:0], w_qbit};
            r_rem  <= w_qbit ? w_diff[W-1:0] : w_shift[W-1:0];
            r_cnt  <= r_cnt + vmx_pkg::CNT_W'(1);
        end
        if (i_cmd.finish) begin
            r_wd   <= n_wd;
            r_res  <= n_res;
            r_wr   <= n_wr;
            r_remv <= n_remv;
            r_jt   <= n_jt;
            r_tgt  <= n_tgt;
            r_derr <= n_derr;
        end
    end

    assign o_write_dest      = r_wd;
    assign o_result_value    = r_res;
    assign o_write_remainder = r_wr;
    assign o_remainder_value = r_remv;
    assign o_jump_taken      = r_jt;
    assign o_jump_target     = r_tgt;
    assign o_divide_error    = r_derr;
    assign o_flags_now       = r_flags;

endmodule

// ===== design/vm_execute_unit_with_flags_unit.sv =====
// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_stall    i_command, i_value_a, i_value_b
// result    out        o_valid / i_stall    write, jump, error and flag fields
//
// One request is in flight at a time; o_stall is high from acceptance until the
// result is taken. A result is registered in EXEC, shown in OUT; DIV with a nonzero
// divisor also passes DIV and DFIN; the restoring divider retires one quotient
// bit per cycle. Synchronous active-low reset clears the flags and the controller.
// A stalled result holds its fields until it is taken.
module vm_execute_unit_with_flags_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [4:0]                    i_command,
    input  logic [vmx_pkg::WORD_BITS-1:0] i_value_a,
    input  logic [vmx_pkg::WORD_BITS-1:0] i_value_b,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_write_dest,
    output logic [vmx_pkg::WORD_BITS-1:0] o_result_value,
    output logic                          o_write_remainder,
    output logic [vmx_pkg::WORD_BITS-1:0] o_remainder_value,
    output logic                          o_jump_taken,
    output logic [vmx_pkg::WORD_BITS-1:0] o_jump_target,
    output logic                          o_divide_error,
    output logic [3:0]                    o_flags_now
);

    vmx_pkg::t_dp_cmd    w_cmd;
    vmx_pkg::t_dp_status w_status;

    vmx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_stall     (i_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid)
    );

    vmx_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_command         (i_command),
        .i_value_a         (i_value_a),
        .i_value_b         (i_value_b),
        .o_status          (w_status),
        .o_write_dest      (o_write_dest),
        .o_result_value    (o_result_value),
        .o_write_remainder (o_write_remainder),
        .o_remainder_value (o_remainder_value),
        .o_jump_taken      (o_jump_taken),
        .o_jump_target     (o_jump_target),
        .o_divide_error    (o_divide_error),
        .o_flags_now       (o_flags_now)
    );

`ifndef NO_ASSERTIONS
    a_busy_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("request accepted while a result is pending");

    a_rem_with_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_write_remainder |-> o_write_dest && !o_divide_error)
        else $error("remainder write without quotient write");

    a_error_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_error |-> !o_write_dest && !o_jump_taken)
        else $error("divide error together with a write or jump");

    a_flags_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_flags_now))
        else $error("more than one flag set");
`endif

endmodule
